[src/lrs_pkg.sv]
// Shared types and constants for the linear ranking selection index block.
// No dependencies.
package lrs_pkg;

	localparam int RAND_W = 16;
	localparam int IDX_W = 10;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int POP_CFG_W = 11;
	localparam int BIAS_W = 16;
	localparam int BIAS_M1_W = 15;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [BIAS_W-1:0] bias_t;

	localparam cfg_idx_t CFG_POP_SIZE = 2'd0;
	localparam cfg_idx_t CFG_BIAS = 2'd1;

	localparam bias_t BIAS_ONE = 16'd16384;
	localparam bias_t BIAS_LO = 16'd16385;
	localparam bias_t BIAS_HI = 16'd32768;
	localparam bias_t BIAS_RESET = 16'd24576;
	localparam int POP_RESET = 1024;

endpackage

[src/lrs_sqrt.sv]
// Pipelined integer square root, one root bit per register stage.
// Standalone; used by linear_ranking_select_index.
module lrs_sqrt #(
	parameter int DW = 47,
	parameter int RW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] radicand,
	output logic          out_valid,
	output logic [RW-1:0] root
);

	localparam int PW = 2 * RW;

	logic          v_s    [RW];
	logic [PW-1:0] rad_s  [RW];
	logic [RW+1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic          p_v;
		logic [PW-1:0] p_rad;
		logic [RW+1:0] p_rem;
		logic [RW-1:0] p_root;
		logic [RW+1:0] rem_sh;
		logic [RW+1:0] trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign p_v = in_valid;
			assign p_rad = PW'(radicand);
			assign p_rem = '0;
			assign p_root = '0;
		end else begin : g_next
			assign p_v = v_s[k-1];
			assign p_rad = rad_s[k-1];
			assign p_rem = rem_s[k-1];
			assign p_root = root_s[k-1];
		end

		assign rem_sh = {p_rem[RW-1:0], p_rad[PW-1 -: 2]};
		assign trial = {p_root, 2'b01};
		assign ge = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= p_rad << 2;
				rem_s[k] <= ge ? rem_sh - trial : rem_sh;
				root_s[k] <= {p_root[RW-2:0], ge};
			end
		end
	end

	assign out_valid = v_s[RW-1];
	assign root = root_s[RW-1];

endmodule

[src/lrs_div.sv]
// Pipelined restoring divider with quotient saturation: an input stage, then one quotient bit per stage.
// Standalone; used by linear_ranking_select_index.
module lrs_div #(
	parameter int NUMW = 35,
	parameter int DENW = 24,
	parameter int QW = 11
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	output logic            out_valid,
	output logic [QW-1:0]   quo,
	output logic            sat
);

	localparam int CW = DENW + QW;

	logic          v_s   [QW+1];
	logic [CW-1:0] rem_s [QW+1];
	logic [QW-1:0] q_s   [QW+1];
	logic          sat_s [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	// quotient would not fit in QW bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= CW'(num);
			sat_s[0] <= CW'(num) >= (CW'(den) << QW);
			q_s[0] <= '0;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_step
		localparam int SH = QW - j;
		logic [CW-1:0] dsh;
		logic          ge;

		assign dsh = CW'(den) << SH;
		assign ge = rem_s[j-1] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? rem_s[j-1] - dsh : rem_s[j-1];
				q_s[j] <= {q_s[j-1][QW-2:0], ge};
				sat_s[j] <= sat_s[j-1];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo = q_s[QW];
	assign sat = sat_s[QW];

endmodule

[src/linear_ranking_select_index.sv]
// Top level of the linear ranking selection index block.
// Depends on lrs_pkg, lrs_sqrt and lrs_div.
//
// Turns one uniform random fraction into the rank index of a parent under linear
// ranking selection, index = floor(n*(b - sqrt(b*b - 4*(b-1)*r)) / (2*(b-1))), clamped
// to n-1. One beat is accepted every cycle while rand_stall is low. The pipeline has
// RW = (28 + FRAC_BITS rounded up to even)/2 + 2 square-root stages and a divider for
// QW = clog2(POP_MAX) + 1 quotient bits. The square root produces one root bit per stage
// and the divider one quotient bit per stage after its input stage. A two-entry
// output buffer lets the pipeline take a new beat while a result waits.
// Configuration writes are saturated into range as they are stored and must only be
// made while no beat is in flight.
module linear_ranking_select_index #(
	parameter int POP_MAX = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  lrs_pkg::cfg_idx_t             cfg_index,
	input  logic [lrs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          rand_valid,
	output logic                          rand_stall,
	input  logic [lrs_pkg::RAND_W-1:0]    random_fraction,
	output logic                          sel_valid,
	input  logic                          sel_stall,
	output logic [lrs_pkg::IDX_W-1:0]     selected_index
);

	localparam int E = ((28 + FRAC_BITS + 1) / 2) * 2;
	localparam int H = E / 2;
	localparam int DW = E + 3;
	localparam int DXW = E + 18;
	localparam int RW = H + 2;
	localparam int NW = $clog2(POP_MAX + 1);
	localparam int QW = $clog2(POP_MAX) + 1;
	localparam int NUMW = NW + RW;
	localparam int POP_RST = (POP_MAX < lrs_pkg::POP_RESET) ? POP_MAX : lrs_pkg::POP_RESET;

	// configuration
	logic [NW-1:0]                 n_q;
	lrs_pkg::bias_t                b_q;
	logic [lrs_pkg::BIAS_M1_W-1:0] bm1_q;
	logic [31:0]                   n_wr;
	lrs_pkg::bias_t                b_wr;

	assign cfg_ready = 1'b1;

	always_comb begin
		n_wr = 32'(cfg_data[lrs_pkg::POP_CFG_W-1:0]);
		if (n_wr == 32'd0) begin
			n_wr = 32'd1;
		end else if (n_wr > 32'(POP_MAX)) begin
			n_wr = 32'(POP_MAX);
		end
		b_wr = cfg_data[lrs_pkg::BIAS_W-1:0];
		if (b_wr < lrs_pkg::BIAS_LO) begin
			b_wr = lrs_pkg::BIAS_LO;
		end else if (b_wr > lrs_pkg::BIAS_HI) begin
			b_wr = lrs_pkg::BIAS_HI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= NW'(POP_RST);
			b_q <= lrs_pkg::BIAS_RESET;
			bm1_q <= lrs_pkg::BIAS_M1_W'(lrs_pkg::BIAS_RESET - lrs_pkg::BIAS_ONE);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lrs_pkg::CFG_POP_SIZE: begin
					n_q <= NW'(n_wr);
				end
				lrs_pkg::CFG_BIAS: begin
					b_q <= b_wr;
					bm1_q <= lrs_pkg::BIAS_M1_W'(b_wr - lrs_pkg::BIAS_ONE);
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline control
	logic en;
	logic sk_valid_q;

	assign en = !sk_valid_q;
	assign rand_stall = sk_valid_q;

	// s1: b*b and (b-1)*r
	logic        v_s1;
	logic [30:0] bb_s1;
	logic [29:0] pr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= rand_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1 <= 31'(b_q) * 31'(b_q);
			pr_s1 <= 30'(bm1_q) * 30'(random_fraction);
		end
	end

	// s2: discriminant, clamped at zero
	logic           v_s2;
	logic [DW-1:0]  d_s2;
	logic [DXW-1:0] sq;
	logic [DXW-1:0] sub;

	assign sq = DXW'(bb_s1) << (E - 28);
	assign sub = DXW'(pr_s1) << (E - 12 - FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2 <= (sq > sub) ? DW'(sq - sub) : '0;
		end
	end

	logic          sqrt_valid;
	logic [RW-1:0] sqrt_root;

	lrs_sqrt #(
		.DW(DW),
		.RW(RW)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s2),
		.radicand(d_s2),
		.out_valid(sqrt_valid),
		.root(sqrt_root)
	);

	// s3: b - sqrt, clamped at zero
	logic          v_s3;
	logic [RW-1:0] diff_s3;
	logic [RW-1:0] bsh;

	assign bsh = RW'(b_q) << (H - 14);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sqrt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s3 <= (bsh > sqrt_root) ? bsh - sqrt_root : '0;
		end
	end

	// s4: n * diff
	logic            v_s4;
	logic [NUMW-1:0] num_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= NUMW'(n_q) * NUMW'(diff_s3);
		end
	end

	logic          div_valid;
	logic [QW-1:0] div_quo;
	logic          div_sat;
	logic [RW-1:0] den;

	assign den = RW'(bm1_q) << (H - 13);

	lrs_div #(
		.NUMW(NUMW),
		.DENW(RW),
		.QW(QW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s4),
		.num(num_s4),
		.den(den),
		.out_valid(div_valid),
		.quo(div_quo),
		.sat(div_sat)
	);

	// clamp to n-1 and buffer the result
	logic [QW-1:0]             n_m1;
	logic [QW-1:0]             idx;
	logic                      out_valid_q;
	logic [lrs_pkg::IDX_W-1:0] out_idx_q;
	logic [lrs_pkg::IDX_W-1:0] sk_idx_q;

	assign n_m1 = QW'(n_q - NW'(1));
	assign idx = (div_sat || (div_quo > n_m1)) ? n_m1 : div_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q <= 1'b0;
		end else if (sk_valid_q) begin
			if (!sel_stall) begin
				sk_valid_q <= 1'b0;
			end
		end else if (div_valid) begin
			if (out_valid_q && sel_stall) begin
				sk_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (!sel_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_valid_q) begin
			if (!sel_stall) begin
				out_idx_q <= sk_idx_q;
			end
		end else if (div_valid) begin
			if (out_valid_q && sel_stall) begin
				sk_idx_q <= lrs_pkg::IDX_W'(idx);
			end else begin
				out_idx_q <= lrs_pkg::IDX_W'(idx);
			end
		end
	end

	assign sel_valid = out_valid_q;
	assign selected_index = out_idx_q;

endmodule
